FILE: sv/frame_pacer_with_frameskip_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame pacer
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_PACER_WITH_FRAMESKIP_ASSERT_SVH
`define FRAME_PACER_WITH_FRAMESKIP_ASSERT_SVH

`ifndef SYNTH
`define FPFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FPFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FPFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FPFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/fpfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfs_pkg
// Types and constants of the frame pacer with frameskip.
// ----------------------------------------------------------------------------
package fpfs_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] wait_kind_t;

    localparam cmd_t CMD_RESTART    = 2'd0;
    localparam cmd_t CMD_FRAME_END  = 2'd1;
    localparam cmd_t CMD_VSYNC_DONE = 2'd2;

    localparam wait_kind_t WAIT_NONE  = 2'd0;
    localparam wait_kind_t WAIT_TIME  = 2'd1;
    localparam wait_kind_t WAIT_VSYNC = 2'd2;

    localparam int unsigned PERIOD_PAL   = 19997;
    localparam int unsigned PERIOD_NTSC  = 16639;
    localparam int unsigned RESYNC_LIMIT = 92 * 1024;
    localparam int unsigned EARLY_MARGIN = 5000;

    localparam int MAX_AUTO_SKIP_DEFAULT = 6;
    localparam int TIME_BITS_DEFAULT     = 32;

    localparam int SKIP_RUN_BITS = 4;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int FIXED_SKIP_BITS = 5;

    typedef logic [APB_ADDR_BITS-1:0] apb_addr_t;
    typedef logic [APB_DATA_BITS-1:0] apb_data_t;

    localparam logic [1:0] REG_PAL_MODE   = 2'd0;
    localparam logic [1:0] REG_FIXED_SKIP = 2'd1;
    localparam logic [1:0] REG_VSYNC_MODE = 2'd2;

endpackage

FILE: sv/frame_pacer_with_frameskip.sv
// An accepted item's result is registered in the output register at the accept
// edge. Throughput: one item per cycle; the pacing state updates at that edge,
// so the next item sees it at once. The output register stalls input only
// when full and not taken. rst_n clears the pacing state and output valid and
// resets the configuration registers; no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacer_with_frameskip
// Frame pacer: per command, decides frameskip and the wait kind and target.
// ----------------------------------------------------------------------------
module frame_pacer_with_frameskip
#(
    parameter int MAX_AUTO_SKIP = fpfs_pkg::MAX_AUTO_SKIP_DEFAULT,
    parameter int TIME_BITS     = fpfs_pkg::TIME_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  fpfs_pkg::apb_addr_t  paddr,
    input  fpfs_pkg::apb_data_t  pwdata,
    output fpfs_pkg::apb_data_t  prdata,
    output logic                 pready,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  fpfs_pkg::cmd_t       command,
    input  logic [31:0]          now_us,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 skip_frame,
    output fpfs_pkg::wait_kind_t wait_kind,
    output logic [31:0]          wait_until_us
);
    import fpfs_pkg::*;

    `include "frame_pacer_with_frameskip_assert.svh"

    typedef logic [TIME_BITS-1:0] time_t;

    logic                       pal_mode_reg;
    logic [FIXED_SKIP_BITS-1:0] fixed_skip_reg;
    logic                       vsync_mode_reg;
    logic                       cfg_write;

    time_t                      ref_time_reg;
    time_t                      ref_time_next;
    logic [SKIP_RUN_BITS-1:0]   skip_run_reg;
    logic [SKIP_RUN_BITS-1:0]   skip_run_next;

    logic                       res_valid_reg;
    logic                       skip_frame_reg;
    logic                       skip_frame_next;
    wait_kind_t                 wait_kind_reg;
    wait_kind_t                 wait_kind_next;
    logic [31:0]                wait_until_reg;
    logic [31:0]                wait_until_next;

    logic                       accept;
    time_t                      now_t;
    time_t                      period_t;
    time_t                      aim;
    time_t                      diff;
    logic                       late_neg;
    logic                       auto_skip;
    logic                       behind;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_mode_reg   <= 1'b0;
            fixed_skip_reg <= '1;
            vsync_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PAL_MODE:   pal_mode_reg   <= pwdata[0];
                REG_FIXED_SKIP: fixed_skip_reg <= pwdata[FIXED_SKIP_BITS-1:0];
                REG_VSYNC_MODE: vsync_mode_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PAL_MODE:   prdata = APB_DATA_BITS'(pal_mode_reg);
            REG_FIXED_SKIP: prdata = APB_DATA_BITS'(signed'(fixed_skip_reg));
            REG_VSYNC_MODE: prdata = APB_DATA_BITS'(vsync_mode_reg);
            default:        prdata = '0;
        endcase
    end

    // item handshake
    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;

    // frame-end arithmetic
    assign now_t     = TIME_BITS'(now_us);
    assign period_t  = pal_mode_reg ? TIME_BITS'(PERIOD_PAL) : TIME_BITS'(PERIOD_NTSC);
    assign aim       = ref_time_reg + period_t;
    assign diff      = now_t - aim;
    assign late_neg  = diff[TIME_BITS-1];
    assign auto_skip = fixed_skip_reg[FIXED_SKIP_BITS-1];
    assign behind    = auto_skip && !late_neg && (diff >= period_t);

    always_comb
    begin
        ref_time_next   = ref_time_reg;
        skip_run_next   = skip_run_reg;
        skip_frame_next = 1'b0;
        wait_kind_next  = WAIT_NONE;
        wait_until_next = '0;
        case (command)
            CMD_RESTART:
            begin
                skip_run_next = '0;
                ref_time_next = now_t - period_t;
            end
            CMD_VSYNC_DONE:
            begin
                ref_time_next = now_t;
            end
            CMD_FRAME_END:
            begin
                if (!auto_skip)
                begin
                    if (skip_run_reg >= fixed_skip_reg[SKIP_RUN_BITS-1:0])
                        skip_run_next = '0;
                    else
                    begin
                        skip_run_next   = skip_run_reg + 1'b1;
                        skip_frame_next = 1'b1;
                    end
                end
                else if (behind)
                begin
                    if (skip_run_reg < SKIP_RUN_BITS'(MAX_AUTO_SKIP))
                    begin
                        skip_run_next   = skip_run_reg + 1'b1;
                        skip_frame_next = 1'b1;
                    end
                    else
                        skip_run_next = '0;
                end
                else
                    skip_run_next = '0;

                if (behind)
                    ref_time_next = (diff < TIME_BITS'(RESYNC_LIMIT)) ? aim : now_t;
                else if (late_neg && vsync_mode_reg)
                begin
                    // reference waits for the vsync done report
                    wait_kind_next  = WAIT_VSYNC;
                    wait_until_next = 32'(aim - TIME_BITS'(EARLY_MARGIN));
                end
                else if (late_neg)
                begin
                    ref_time_next   = aim;
                    wait_kind_next  = WAIT_TIME;
                    wait_until_next = 32'(aim);
                end
                else
                    ref_time_next = aim;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_time_reg  <= '0;
            skip_run_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ref_time_reg  <= ref_time_next;
                skip_run_reg  <= skip_run_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            skip_frame_reg <= skip_frame_next;
            wait_kind_reg  <= wait_kind_next;
            wait_until_reg <= wait_until_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign skip_frame    = skip_frame_reg;
    assign wait_kind     = wait_kind_reg;
    assign wait_until_us = wait_until_reg;

    `FPFS_ASSERT_IMP(a_no_wait_zero_time, clk, rst_n, res_valid && wait_kind == WAIT_NONE, wait_until_us == 32'd0, "wait target set without a wait")
    `FPFS_ASSERT_NXT(a_non_frame_quiet, clk, rst_n, accept && command != CMD_FRAME_END, !skip_frame && wait_kind == WAIT_NONE, "non frame-end item gave a skip or wait")
    `FPFS_ASSERT_NXT(a_restart_clears_run, clk, rst_n, accept && command == CMD_RESTART, skip_run_reg == '0, "restart left a skip run")

endmodule
